[sv/nnz_pkg.sv]
// nnz_pkg: shared types and constants of the nearest-neighbor zoom preview.
// No dependencies; imported by every module of the block.
`default_nettype none
package nnz_pkg;

   // request operation codes
   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_READ  = 1'b1
   } op_type;

   // configuration register indexes
   localparam logic [1:0] CSR_SCALE_STEP = 2'd0;
   localparam logic [1:0] CSR_ORIGIN_X   = 2'd1;
   localparam logic [1:0] CSR_ORIGIN_Y   = 2'd2;
   localparam logic [1:0] CSR_BACKGROUND = 2'd3;

   // register reset values
   localparam logic [23:0] SCALE_STEP_RESET = 24'h010000;
   localparam logic [31:0] ORIGIN_RESET     = 32'h00000000;
   localparam logic [15:0] BACKGROUND_RESET = 16'hFFFF;

   // 16.16 rounding half, at the width of the mapping sum
   localparam logic signed [33:0] FIX_HALF = 34'sd32768;

   // control word handed from the mapping stage to the frame store
   typedef struct packed {
      logic rsp_valid;   // a read request whose result follows
      logic mem_write;   // a write request inside the frame
      logic in_range;    // mapped source inside the frame
   } stage_ctl_type;

endpackage
`default_nettype wire

[sv/nearest_neighbor_zoom_preview_top.sv]
// nearest_neighbor_zoom_preview_top: nearest-neighbor zoom over a stored frame.
// Throughput: one request per cycle; busy stays low, results cannot be held off.
// Reset (synchronous, active high) restores the registers; the frame is undefined.
// Pipeline: input reg, multiply reg, map reg, frame store read reg, result reg.
// Depends on nnz_pkg, nnz_map, nnz_frame_store.
`default_nettype none
module nearest_neighbor_zoom_preview_top #(
   parameter int FRAME_WIDTH  = 256,
   parameter int FRAME_HEIGHT = 256,
   parameter int PIXEL_BITS   = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         start,
   output logic              busy,
   input  wire logic         req_operation,
   input  wire logic [7:0]   req_pixel_x,
   input  wire logic [7:0]   req_pixel_y,
   input  wire logic [15:0]  req_pixel_value,
   // result channel
   output logic              rsp_valid,
   output logic [15:0]       rsp_pixel_out,
   output logic              rsp_in_range,
   // configuration
   input  wire logic         csr_write_enable,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_write_data
);
   import nnz_pkg::*;

   localparam int ADDR_BITS = $clog2(FRAME_WIDTH * FRAME_HEIGHT);

   // configuration registers
   logic [23:0]        scale_step_ff;
   logic signed [31:0] origin_x_ff;
   logic signed [31:0] origin_y_ff;
   logic [15:0]        background_ff;

   // input register
   logic        req_valid_ff;
   logic        req_op_ff;
   logic [7:0]  req_x_ff, req_y_ff;
   logic [15:0] req_val_ff;

   // between map stage and frame store
   stage_ctl_type        map_ctl;
   logic [ADDR_BITS-1:0] map_addr;
   logic [15:0]          map_wdata;

   logic        store_valid, store_in_range;
   logic [15:0] store_rdata;

   // result register
   logic        rsp_valid_ff;
   logic [15:0] rsp_pixel_ff, rsp_pixel_in;
   logic        rsp_in_range_ff;

   // every stage advances each cycle, so a request is always taken
   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_step_ff <= SCALE_STEP_RESET;
         origin_x_ff   <= ORIGIN_RESET;
         origin_y_ff   <= ORIGIN_RESET;
         background_ff <= BACKGROUND_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SCALE_STEP: scale_step_ff <= csr_write_data[23:0];
            CSR_ORIGIN_X:   origin_x_ff   <= csr_write_data;
            CSR_ORIGIN_Y:   origin_y_ff   <= csr_write_data;
            CSR_BACKGROUND: background_ff <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
      req_op_ff  <= req_operation;
      req_x_ff   <= req_pixel_x;
      req_y_ff   <= req_pixel_y;
      req_val_ff <= req_pixel_value;
   end

   nnz_map #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT),
      .ADDR_BITS    (ADDR_BITS)
   ) u_map (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_valid_ff),
      .in_operation   (req_op_ff),
      .in_pixel_x     (req_x_ff),
      .in_pixel_y     (req_y_ff),
      .in_pixel_value (req_val_ff),
      .scale_step     (scale_step_ff),
      .origin_x       (origin_x_ff),
      .origin_y       (origin_y_ff),
      .ctl_out        (map_ctl),
      .addr_out       (map_addr),
      .wdata_out      (map_wdata)
   );

   nnz_frame_store #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT),
      .PIXEL_BITS   (PIXEL_BITS),
      .ADDR_BITS    (ADDR_BITS)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (map_ctl),
      .addr      (map_addr),
      .wdata     (map_wdata),
      .rsp_valid (store_valid),
      .in_range  (store_in_range),
      .rdata     (store_rdata)
   );

   // outside the frame the background color goes out instead of memory data;
   // the user must change config only while idle, which the block does not enforce; the live register is read here
   assign rsp_pixel_in = store_in_range ? store_rdata : background_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= store_valid;
      end
      rsp_pixel_ff    <= rsp_pixel_in;
      rsp_in_range_ff <= store_in_range;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_in_range  = rsp_in_range_ff;

endmodule
`default_nettype wire

[sv/nnz_map.sv]
// nnz_map: two-stage coordinate mapping, multiply then offset/round/range check.
// Depends on nnz_pkg; produces the frame store address and control word.
`default_nettype none
module nnz_map #(
   parameter int FRAME_WIDTH  = 256,
   parameter int FRAME_HEIGHT = 256,
   parameter int ADDR_BITS    = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire logic                  in_operation,
   input  wire logic [7:0]            in_pixel_x,
   input  wire logic [7:0]            in_pixel_y,
   input  wire logic [15:0]           in_pixel_value,
   input  wire logic [23:0]           scale_step,
   input  wire logic signed [31:0]    origin_x,
   input  wire logic signed [31:0]    origin_y,
   output nnz_pkg::stage_ctl_type     ctl_out,
   output logic [ADDR_BITS-1:0]       addr_out,
   output logic [15:0]                wdata_out
);
   import nnz_pkg::*;

   localparam int XB = (FRAME_WIDTH  > 1) ? $clog2(FRAME_WIDTH)  : 1;
   localparam int YB = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;

   // multiply stage
   logic        s2_valid_ff, s2_valid_in;
   logic        s2_op_ff;
   logic [7:0]  s2_x_ff, s2_y_ff;
   logic [15:0] s2_val_ff;
   logic [31:0] prod_x_ff, prod_x_in;
   logic [31:0] prod_y_ff, prod_y_in;

   // map stage
   stage_ctl_type          ctl_ff, ctl_in;
   logic [ADDR_BITS-1:0]   addr_ff, addr_in;
   logic [15:0]            wdata_ff;

   logic signed [33:0] sum_x, sum_y;
   logic [17:0]        src_x, src_y;
   logic               inside_x, inside_y, wr_inside;
   logic [XB-1:0]      col_idx;
   logic [YB-1:0]      row_idx;

   assign s2_valid_in = in_valid;
   assign prod_x_in   = {24'd0, in_pixel_x} * {8'd0, scale_step};
   assign prod_y_in   = {24'd0, in_pixel_y} * {8'd0, scale_step};

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
      s2_op_ff  <= in_operation;
      s2_x_ff   <= in_pixel_x;
      s2_y_ff   <= in_pixel_y;
      s2_val_ff <= in_pixel_value;
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
   end

   // floor((origin + coord*step + half) / 2^16) via arithmetic shift
   always_comb begin
      sum_x = $signed({{2{origin_x[31]}}, origin_x}) + $signed({2'b00, prod_x_ff}) + FIX_HALF;
      sum_y = $signed({{2{origin_y[31]}}, origin_y}) + $signed({2'b00, prod_y_ff}) + FIX_HALF;
      src_x = sum_x[33:16];
      src_y = sum_y[33:16];
      inside_x  = !src_x[17] && (src_x[16:0] < 17'(FRAME_WIDTH));
      inside_y  = !src_y[17] && (src_y[16:0] < 17'(FRAME_HEIGHT));
      wr_inside = (32'(s2_x_ff) < 32'(FRAME_WIDTH)) && (32'(s2_y_ff) < 32'(FRAME_HEIGHT));

      if (s2_op_ff == OP_WRITE) begin
         col_idx = XB'(s2_x_ff);
         row_idx = YB'(s2_y_ff);
      end else begin
         col_idx = XB'(src_x);
         row_idx = YB'(src_y);
      end
      addr_in = ADDR_BITS'(row_idx) * ADDR_BITS'(FRAME_WIDTH) + ADDR_BITS'(col_idx);

      ctl_in.rsp_valid = s2_valid_ff && (s2_op_ff == OP_READ);
      ctl_in.mem_write = s2_valid_ff && (s2_op_ff == OP_WRITE) && wr_inside;
      ctl_in.in_range  = inside_x && inside_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      addr_ff  <= addr_in;
      wdata_ff <= s2_val_ff;
   end

   assign ctl_out   = ctl_ff;
   assign addr_out  = addr_ff;
   assign wdata_out = wdata_ff;

endmodule
`default_nettype wire

[sv/nnz_frame_store.sv]
// nnz_frame_store: single-port source frame memory with registered read data.
// Depends on nnz_pkg for the stage control word.
`default_nettype none
module nnz_frame_store #(
   parameter int FRAME_WIDTH  = 256,
   parameter int FRAME_HEIGHT = 256,
   parameter int PIXEL_BITS   = 16,
   parameter int ADDR_BITS    = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire nnz_pkg::stage_ctl_type ctl_in,
   input  wire logic [ADDR_BITS-1:0]  addr,
   input  wire logic [15:0]           wdata,
   output logic                       rsp_valid,
   output logic                       in_range,
   output logic [15:0]                rdata
);
   import nnz_pkg::*;

   localparam int DEPTH      = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int STORE_BITS = (PIXEL_BITS < 16) ? PIXEL_BITS : 16;

   logic [STORE_BITS-1:0] frame_mem [DEPTH];
   logic [STORE_BITS-1:0] rdata_ff;
   logic                  rsp_valid_ff;
   logic                  in_range_ff;

   // a stage holds one request, so a cycle is either a write or a read
   always_ff @(posedge clock) begin
      if (ctl_in.mem_write) begin
         frame_mem[addr] <= STORE_BITS'(wdata);
      end
      rdata_ff <= frame_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl_in.rsp_valid;
      end
      in_range_ff <= ctl_in.in_range;
   end

   assign rsp_valid = rsp_valid_ff;
   assign in_range  = in_range_ff;
   assign rdata     = 16'(rdata_ff);

endmodule
`default_nettype wire

[sv/nnz_checker.sv]
// nnz_checker: port-level timing checks of the zoom preview, bound to the top.
// Depends on nnz_pkg and nearest_neighbor_zoom_preview_top.
`default_nettype none
module nnz_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         start,
   input wire logic         busy,
   input wire logic         req_operation,
   input wire logic         rsp_valid,
   input wire logic         rsp_in_range
);
   import nnz_pkg::*;

   // the pipeline never stalls
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   // a read request gives a result strobe
   a_read_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == OP_READ) |-> ##5 rsp_valid)
      else $error("read request without result");

   // a write request gives no result
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == OP_WRITE) |-> ##5 !rsp_valid)
      else $error("write request produced a result");

   // a strobed result always carries a defined range flag
   a_range_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_in_range))
      else $error("result range flag unknown");

   // reset clears the result strobe
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

endmodule

bind nearest_neighbor_zoom_preview_top nnz_checker u_nnz_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_operation (req_operation),
   .rsp_valid     (rsp_valid),
   .rsp_in_range  (rsp_in_range)
);
`default_nettype wire
